// ----- hdl/nfba_pkg.sv -----
// ----------------------------------------------------------------------------
// nfba_pkg
// Shared types and constants of the next-fit block allocator.
// ----------------------------------------------------------------------------
package nfba_pkg;

	localparam int unsigned NumBlocksDef  = 1024;
	localparam int unsigned NumRecordsDef = 256;
	localparam int unsigned AddrW         = 48;
	localparam int unsigned BytesW        = 32;
	localparam int unsigned ShiftW        = 5;
	localparam int unsigned CfgW          = 48;
	localparam int unsigned IdxOutW       = 8;
	localparam int unsigned ShiftReset    = 12;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_REC   = 2'd1,
		ST_NO_SPACE = 2'd2,
		ST_UNKNOWN  = 2'd3
	} status_t;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic {
		CFG_BASE  = 1'b0,
		CFG_SHIFT = 1'b1
	} cfg_idx_t;

	// Classified request handed from the front part to the back part
	typedef struct packed {
		cmd_t              cmd;
		logic [BytesW-1:0] bytes;
		logic [AddrW-1:0]  addr;
		logic              too_big;
	} req_t;

	// Compute the block count needed for a byte count
	function automatic logic [BytesW:0] blocks_needed(input logic [BytesW-1:0] bytes,
		input logic [ShiftW-1:0] shift);
		blocks_needed = {1'b0, bytes >> shift} + {{BytesW{1'b0}}, 1'b1};
	endfunction

endpackage

// ----- hdl/nfba_ram.sv -----
// ----------------------------------------------------------------------------
// nfba_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nfba_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hdl/nfba_front.sv -----
// ----------------------------------------------------------------------------
// nfba_front
// Accepts requests, classifies them and queues them for the back part.
// ----------------------------------------------------------------------------
module nfba_front #(
	parameter int unsigned NumBlocks = nfba_pkg::NumBlocksDef
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         command,
	input  logic [nfba_pkg::BytesW-1:0]  request_bytes,
	input  logic [nfba_pkg::AddrW-1:0]   address,
	input  logic [nfba_pkg::ShiftW-1:0]  shift,
	output logic                         q_valid,
	output nfba_pkg::req_t               q_req,
	input  logic                         q_pop
);

	nfba_pkg::req_t slot_q [2];
	logic [1:0] cnt_q;
	logic       rd_q, wr_q;
	logic       push;
	nfba_pkg::req_t nreq;
	logic [nfba_pkg::BytesW:0] need;

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_req    = slot_q[rd_q];

	always_comb begin
		need         = nfba_pkg::blocks_needed(request_bytes, shift);
		nreq.cmd     = nfba_pkg::cmd_t'(command);
		nreq.bytes   = request_bytes;
		nreq.addr    = address;
		nreq.too_big = ({31'd0, need} > 64'(NumBlocks));
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= nreq;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (q_pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

// ----- hdl/nfba_back.sv -----
// ----------------------------------------------------------------------------
// nfba_back
// Carries out allocate and free requests over the block bitmap and the
// record table; a new request is taken only once the last result has left.
// ----------------------------------------------------------------------------
module nfba_back #(
	parameter int unsigned NumBlocks  = nfba_pkg::NumBlocksDef,
	parameter int unsigned NumRecords = nfba_pkg::NumRecordsDef
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [nfba_pkg::AddrW-1:0]     base,
	input  logic [nfba_pkg::ShiftW-1:0]    shift,
	input  logic                           q_valid,
	input  nfba_pkg::req_t                 q_req,
	output logic                           q_pop,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     status,
	output logic [nfba_pkg::AddrW-1:0]     granted_address,
	output logic [nfba_pkg::IdxOutW-1:0]   record_index
);

	localparam int unsigned BW = (NumBlocks > 1) ? $clog2(NumBlocks) : 1;
	localparam int unsigned RW = (NumRecords > 1) ? $clog2(NumRecords) : 1;
	localparam int unsigned CW = BW + 1;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_RSCAN, S_BSCAN, S_BMARK, S_FREAD, S_FCHK,
		S_FCLR, S_OUT
	} state_t;

	state_t state_q;
	logic [BW-1:0] clr_q;
	logic [RW-1:0] ri_q, rec_q, rcur_q;
	logic [RW:0]   rcnt_q;
	logic [BW-1:0] bi_q, start_q, bcur_q, end_q;
	logic [CW-1:0] run_q, need_q;
	logic          wrap_q;
	nfba_pkg::req_t req_q;
	logic [NumRecords-1:0] rvalid_q;

	// bitmap memory
	logic          bm_we;
	logic [BW-1:0] bm_wa, bm_ra;
	logic          bm_wd, bm_rd;
	nfba_ram #(.Width(1), .Depth(NumBlocks)) u_bitmap (
		.clk, .we(bm_we), .waddr(bm_wa), .wdata(bm_wd), .raddr(bm_ra), .rdata(bm_rd)
	);

	// record memory: start block and bytes
	localparam int unsigned RecW = BW + nfba_pkg::BytesW;
	logic            rm_we;
	logic [RecW-1:0] rm_wd, rm_rd;
	nfba_ram #(.Width(RecW), .Depth(NumRecords)) u_records (
		.clk, .we(rm_we), .waddr(rec_q), .wdata(rm_wd), .raddr(ri_q), .rdata(rm_rd)
	);

	logic [BW-1:0]              rd_start;
	logic [nfba_pkg::BytesW-1:0] rd_bytes;
	logic [nfba_pkg::AddrW-1:0] rd_addr;
	logic [nfba_pkg::BytesW:0]  fneed;
	logic [nfba_pkg::BytesW+1:0] fend;
	logic [nfba_pkg::BytesW:0]  aneed;
	logic [BW-1:0]              bi_next;

	assign rd_start = rm_rd[RecW-1 -: BW];
	assign rd_bytes = rm_rd[nfba_pkg::BytesW-1:0];
	assign rd_addr  = base + (nfba_pkg::AddrW'(rd_start) << shift);
	assign fneed    = nfba_pkg::blocks_needed(rd_bytes, shift);
	assign fend     = {1'b0, fneed} + (nfba_pkg::BytesW+2)'(rd_start);
	assign aneed    = nfba_pkg::blocks_needed(req_q.bytes, shift);
	assign bi_next  = bi_q + BW'(1);

	// bitmap port use
	always_comb begin
		bm_we = 1'b0;
		bm_wa = bi_q;
		bm_wd = 1'b0;
		bm_ra = bi_q;
		unique case (state_q)
			S_CLEAR: begin
				bm_we = 1'b1;
				bm_wa = clr_q;
			end
			S_BMARK: begin
				bm_we = (run_q != need_q);
				bm_wa = start_q;
				bm_wd = 1'b1;
			end
			S_FCLR: begin
				bm_we = 1'b1;
				bm_wa = start_q;
			end
			S_BSCAN: bm_ra = end_q[0] ? bi_next : bi_q;
			default: bm_ra = bi_q;
		endcase
	end

	assign rm_we = (state_q == S_BMARK) && (run_q == need_q);
	assign rm_wd = {bi_q - BW'(need_q - CW'(1)), req_q.bytes};
	assign q_pop = (state_q == S_IDLE) && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_CLEAR;
			clr_q           <= '0;
			rvalid_q        <= '0;
			bcur_q          <= '0;
			rcur_q          <= '0;
			out_valid       <= 1'b0;
			status          <= nfba_pkg::ST_OK;
			granted_address <= '0;
			record_index    <= '0;
			ri_q <= '0; rec_q <= '0; rcnt_q <= '0; bi_q <= '0; start_q <= '0;
			end_q <= '0; run_q <= '0; need_q <= '0; wrap_q <= 1'b0;
			req_q <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + BW'(1);
					if (32'(clr_q) == NumBlocks - 1) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (q_valid) begin
						req_q <= q_req;
						if (q_req.cmd == nfba_pkg::CMD_ALLOC) begin
							ri_q    <= rcur_q;
							rcnt_q  <= '0;
							state_q <= S_RSCAN;
						end else begin
							ri_q    <= '0;
							state_q <= S_FREAD;
						end
					end
				end
				S_RSCAN: begin
					if (!rvalid_q[ri_q]) begin
						rec_q <= ri_q;
						if (req_q.too_big) begin
							status  <= nfba_pkg::ST_NO_SPACE;
							state_q <= S_OUT;
						end else begin
							need_q  <= CW'(aneed);
							bi_q    <= bcur_q;
							run_q   <= '0;
							wrap_q  <= 1'b0;
							state_q <= S_BSCAN;
						end
						// bitmap read for bcur is issued in next state via bm_ra = bi_q
					end else if (32'(rcnt_q) == NumRecords - 1) begin
						status  <= nfba_pkg::ST_NO_REC;
						state_q <= S_OUT;
					end else begin
						rcnt_q <= rcnt_q + 1'b1;
						ri_q   <= (32'(ri_q) == NumRecords - 1) ? '0 : ri_q + RW'(1);
					end
				end
				S_BSCAN: begin
					if (!end_q[0]) begin
						end_q[0] <= 1'b1; // read latency slot
					end else begin
						if (bm_rd) begin
							run_q <= '0;
						end else if (run_q + CW'(1) == need_q) begin
							start_q <= bi_q - BW'(need_q - CW'(1));
							run_q   <= '0;
							state_q <= S_BMARK;
						end else begin
							run_q <= run_q + CW'(1);
						end
						if (!(!bm_rd && run_q + CW'(1) == need_q)) begin
							if (!wrap_q && 32'(bi_q) == NumBlocks - 1) begin
								wrap_q   <= 1'b1;
								run_q    <= '0;
								bi_q     <= '0;
								end_q[0] <= 1'b0;
								if (bcur_q == '0) begin
									status  <= nfba_pkg::ST_NO_SPACE;
									state_q <= S_OUT;
								end
							end else if (wrap_q && bi_next == bcur_q) begin
								status  <= nfba_pkg::ST_NO_SPACE;
								state_q <= S_OUT;
							end else begin
								bi_q <= bi_next;
							end
						end
					end
				end
				S_BMARK: begin
					end_q <= '0;
					if (run_q == need_q) begin
						rvalid_q[rec_q] <= 1'b1;
						bcur_q  <= bi_q;
						rcur_q  <= rec_q;
						status  <= nfba_pkg::ST_OK;
						granted_address <= base + (nfba_pkg::AddrW'(bi_q - BW'(need_q - CW'(1)))
							<< shift);
						state_q <= S_OUT;
					end else begin
						bi_q    <= start_q;
						start_q <= start_q + BW'(1);
						run_q   <= run_q + CW'(1);
					end
				end
				S_FREAD: begin
					rcnt_q  <= '0;
					state_q <= S_FCHK;
				end
				S_FCHK: begin
					if (rvalid_q[ri_q] && rd_addr == req_q.addr) begin
						rec_q   <= ri_q;
						rvalid_q[ri_q] <= 1'b0;
						start_q <= rd_start;
						end_q   <= (fend >= (nfba_pkg::BytesW+2)'(NumBlocks)) ? BW'(NumBlocks - 1)
							: BW'(fend - 1'b1);
						status  <= nfba_pkg::ST_OK;
						state_q <= S_FCLR;
					end else if (32'(ri_q) == NumRecords - 1) begin
						status  <= nfba_pkg::ST_UNKNOWN;
						state_q <= S_OUT;
					end else begin
						ri_q    <= ri_q + RW'(1);
						state_q <= S_FREAD;
					end
				end
				S_FCLR: begin
					start_q <= start_q + BW'(1);
					if (start_q == end_q) begin
						end_q   <= '0;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid) begin
						out_valid    <= 1'b1;
						record_index <= (status == nfba_pkg::ST_OK)
							? nfba_pkg::IdxOutW'(32'(rec_q)) : '0;
						if (status != nfba_pkg::ST_OK || req_q.cmd == nfba_pkg::CMD_FREE)
							granted_address <= '0;
					end else if (!out_stall) begin
						out_valid <= 1'b0;
						end_q     <= '0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- hdl/next_fit_block_allocator.sv -----
// ----------------------------------------------------------------------------
// next_fit_block_allocator
// Next-fit allocator over a block bitmap and a table of chunk records.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_stall (command, request_bytes, address) and
// land in a two-entry queue; results leave on out_valid/out_stall (status,
// granted_address, record_index), one per request, in order.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must do so only while idle (not enforced).
// An allocate walks the record table one entry a cycle from the record
// cursor, then the bitmap one block a cycle from the block cursor, then
// marks the run; a free walks the records (each is read, then checked, as
// the memory read is registered) then clears the run. After reset the
// bitmap is cleared block by block; requests queue but are not served
// during the sweep. A stalled result holds in the output register while
// up to two further requests are taken.
// ----------------------------------------------------------------------------
module next_fit_block_allocator #(
	parameter int unsigned NUM_BLOCKS  = nfba_pkg::NumBlocksDef,
	parameter int unsigned NUM_RECORDS = nfba_pkg::NumRecordsDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [nfba_pkg::CfgW-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          command,
	input  logic [nfba_pkg::BytesW-1:0]   request_bytes,
	input  logic [nfba_pkg::AddrW-1:0]    address,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    status,
	output logic [nfba_pkg::AddrW-1:0]    granted_address,
	output logic [nfba_pkg::IdxOutW-1:0]  record_index
);

	logic [nfba_pkg::AddrW-1:0]  base_q;
	logic [nfba_pkg::ShiftW-1:0] shift_q;
	logic q_valid, q_pop;
	nfba_pkg::req_t q_req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			shift_q <= nfba_pkg::ShiftW'(nfba_pkg::ShiftReset);
		end else if (cfg_we) begin
			if (nfba_pkg::cfg_idx_t'(cfg_index) == nfba_pkg::CFG_BASE)
				base_q <= cfg_data;
			else
				shift_q <= cfg_data[nfba_pkg::ShiftW-1:0];
		end
	end

	nfba_front #(.NumBlocks(NUM_BLOCKS)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .command, .request_bytes, .address,
		.shift(shift_q), .q_valid, .q_req, .q_pop
	);

	nfba_back #(.NumBlocks(NUM_BLOCKS), .NumRecords(NUM_RECORDS)) u_back (
		.clk, .arst_n, .base(base_q), .shift(shift_q), .q_valid, .q_req, .q_pop,
		.out_valid, .out_stall, .status, .granted_address, .record_index
	);

	a_ok_alloc_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != nfba_pkg::ST_OK |-> granted_address == '0)
		else $error("failed request carries an address");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status))
		else $error("stalled result changed");
	a_pop_q: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped empty");

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for next_fit_block_allocator: a short table of
// directed requests, then random allocate/free traffic over several
// register settings. Typed rows are checked against the table, all other
// results against an in-bench model of bitmap, chunk records, both cursors.
// ----------------------------------------------------------------------------
module testbench;

	localparam int          NBLK     = 1024;
	localparam int          NREC     = 256;
	localparam int          IDLE_MAX = 40000;
	localparam logic [47:0] ADDR_MAX = 48'hFFFF_FFFF_FFFF;

	typedef struct {
		nfba_pkg::status_t st;
		logic [47:0]       ga;
		logic [7:0]        ri;
	} grant_t;

	typedef struct {
		nfba_pkg::cmd_t cmd;
		logic [31:0]    bytes;
		logic [47:0]    addr;
		bit             typed;
		grant_t         want;
	} row_t;

	typedef struct {
		logic [47:0] base;
		logic [4:0]  shift;
		int          count;
		int          alloc_pct;
		int          max_blocks;
	} phase_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [47:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        command = 1'b0;
	logic [31:0] request_bytes = '0;
	logic [47:0] address = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [47:0] granted_address;
	logic [7:0]  record_index;

	// allocator model
	bit          blk_busy [NBLK];
	bit          rec_live [NREC];
	logic [9:0]  rec_start [NREC];
	logic [31:0] rec_bytes [NREC];
	logic [9:0]  blk_cursor;
	logic [7:0]  rec_cursor;
	logic [47:0] cur_base;
	logic [4:0]  cur_shift;

	grant_t pending_grants [$];
	int     errors = 0;
	int     sent = 0;
	int     seen [4] = '{0, 0, 0, 0};
	int     burst_left = 0;
	int     idle_cycles = 0;
	int     hold_left = 0;
	bit     held = 1'b0;
	int     stall_width = 0;
	int     cyc = 0;

	next_fit_block_allocator i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.command         (command),
		.request_bytes   (request_bytes),
		.address         (address),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.granted_address (granted_address),
		.record_index    (record_index)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [47:0] chunk_addr(input logic [9:0] blk);
		return cur_base + (48'(blk) << cur_shift);
	endfunction

	function automatic logic [63:0] blocks_for(input logic [31:0] bytes);
		return (64'(bytes) >> cur_shift) + 64'd1;
	endfunction

	function automatic bit find_free_run(input int lo, input int hi, input longint need,
		output int start);
		longint run;
		run = 0;
		for (int j = lo; j < hi; j++) begin
			if (blk_busy[j]) begin
				run = 0;
			end else begin
				run++;
				if (run == need) begin
					start = j + 1 - int'(need);
					return 1'b1;
				end
			end
		end
		return 1'b0;
	endfunction

	function automatic grant_t serve_request(input nfba_pkg::cmd_t cmd,
		input logic [31:0] bytes, input logic [47:0] addr);
		grant_t g;
		longint need;
		int     rec;
		int     start;
		bit     got;
		g = '{nfba_pkg::ST_OK, '0, '0};
		if (cmd == nfba_pkg::CMD_ALLOC) begin
			need = blocks_for(bytes);
			got = 1'b0;
			rec = 0;
			for (int i = 0; i < NREC && !got; i++) begin
				if (!rec_live[(int'(rec_cursor) + i) % NREC]) begin
					rec = (int'(rec_cursor) + i) % NREC;
					got = 1'b1;
				end
			end
			if (!got) begin
				g.st = nfba_pkg::ST_NO_REC;
				return g;
			end
			got = 1'b0;
			start = 0;
			if (need <= NBLK) begin
				got = find_free_run(int'(blk_cursor), NBLK, need, start);
				if (!got)
					got = find_free_run(0, int'(blk_cursor), need, start);
			end
			if (!got) begin
				g.st = nfba_pkg::ST_NO_SPACE;
				return g;
			end
			for (int i = 0; i < need; i++)
				blk_busy[start + i] = 1'b1;
			rec_live[rec] = 1'b1;
			rec_start[rec] = 10'(start);
			rec_bytes[rec] = bytes;
			blk_cursor = 10'(start + int'(need) - 1);
			rec_cursor = 8'(rec);
			g.ga = chunk_addr(10'(start));
			g.ri = 8'(rec);
			return g;
		end
		for (int i = 0; i < NREC; i++) begin
			if (rec_live[i] && chunk_addr(rec_start[i]) == addr) begin
				need = blocks_for(rec_bytes[i]);
				for (longint j = rec_start[i]; j < rec_start[i] + need && j < NBLK; j++)
					blk_busy[j] = 1'b0;
				rec_live[i] = 1'b0;
				g.ri = 8'(i);
				return g;
			end
		end
		g.st = nfba_pkg::ST_UNKNOWN;
		return g;
	endfunction

	task automatic write_reg(input nfba_pkg::cfg_idx_t idx, input logic [47:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == nfba_pkg::CFG_BASE)
			cur_base = data;
		else
			cur_shift = data[4:0];
	endtask

	task automatic send_request(input row_t r);
		grant_t g;
		int     gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_valid <= 1'b1;
		command <= r.cmd;
		request_bytes <= r.bytes;
		address <= r.addr;
		do
			@(posedge clk);
		while (in_stall);
		g = serve_request(r.cmd, r.bytes, r.addr);
		pending_grants.push_back(r.typed ? r.want : g);
		sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_grants.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// receiver: own stall pattern, plus one long hold-off
	always @(posedge clk) begin
		cyc++;
		if (cyc % 64 == 0)
			stall_width = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
		if (!held && sent == 150) begin
			held = 1'b1;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= (cyc % 7) < stall_width;
		end
	end

	always @(posedge clk) begin
		grant_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_grants.size() == 0) begin
				$error("unexpected result: status %0d addr %h index %0d",
					status, granted_address, record_index);
				errors++;
			end else begin
				w = pending_grants.pop_front();
				if (status != w.st) begin
					$error("status: expected %0d, got %0d", w.st, status);
					errors++;
				end
				if (granted_address != w.ga) begin
					$error("granted_address: expected %h, got %h", w.ga, granted_address);
					errors++;
				end
				if (record_index != w.ri) begin
					$error("record_index: expected %0d, got %0d", w.ri, record_index);
					errors++;
				end
				seen[w.st]++;
			end
		end
		if ((out_valid && !out_stall) || (in_valid && !in_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles > IDLE_MAX) begin
			$display("testbench: watchdog expired");
			$display("testbench: done, errors");
			$finish;
		end
	end

	function automatic row_t random_request(input phase_t p);
		row_t        r;
		int          k;
		int          probe;
		logic [31:0] fill;
		r.typed = 1'b0;
		r.want = '{nfba_pkg::ST_OK, '0, '0};
		r.bytes = $urandom();
		r.addr = 48'({$urandom(), $urandom()});
		if ($urandom_range(0, 99) < p.alloc_pct) begin
			r.cmd = nfba_pkg::CMD_ALLOC;
			if ($urandom_range(0, 19) != 0) begin
				k = $urandom_range(1, p.max_blocks);
				fill = (cur_shift == 0) ? 32'd0 : ($urandom() & ((32'd1 << cur_shift) - 1));
				r.bytes = (32'(k - 1) << cur_shift) | fill;
			end
		end else begin
			r.cmd = nfba_pkg::CMD_FREE;
			probe = $urandom_range(0, NREC - 1);
			if ($urandom_range(0, 9) != 0) begin
				for (int i = 0; i < NREC; i++) begin
					if (rec_live[(probe + i) % NREC]) begin
						r.addr = chunk_addr(rec_start[(probe + i) % NREC]);
						break;
					end
				end
				if ($urandom_range(0, 9) == 0)
					r.addr = r.addr + 48'd1;
			end
		end
		return r;
	endfunction

	initial begin
		row_t   directed [$];
		phase_t phases [$];
		for (int i = 0; i < NBLK; i++)
			blk_busy[i] = 1'b0;
		for (int i = 0; i < NREC; i++) begin
			rec_live[i] = 1'b0;
			rec_start[i] = '0;
			rec_bytes[i] = '0;
		end
		blk_cursor = '0;
		rec_cursor = '0;
		cur_base = '0;
		cur_shift = 5'(nfba_pkg::ShiftReset);

		directed = '{
			'{nfba_pkg::CMD_ALLOC, 32'd0,         48'd0,    1'b1,
				'{nfba_pkg::ST_OK, 48'd0, 8'd0}},
			'{nfba_pkg::CMD_ALLOC, 32'd4095,      48'd0,    1'b1,
				'{nfba_pkg::ST_OK, 48'h1000, 8'd1}},
			'{nfba_pkg::CMD_FREE,  32'hFFFF_FFFF, 48'd0,    1'b1,
				'{nfba_pkg::ST_OK, 48'd0, 8'd0}},
			'{nfba_pkg::CMD_FREE,  32'd0,         ADDR_MAX, 1'b1,
				'{nfba_pkg::ST_UNKNOWN, 48'd0, 8'd0}},
			'{nfba_pkg::CMD_ALLOC, 32'hFFFF_FFFF, ADDR_MAX, 1'b1,
				'{nfba_pkg::ST_NO_SPACE, 48'd0, 8'd0}},
			'{nfba_pkg::CMD_FREE,  32'd0,         48'h1000, 1'b1,
				'{nfba_pkg::ST_OK, 48'd0, 8'd1}},
			'{nfba_pkg::CMD_ALLOC, 32'd4194303,   48'd0,    1'b0,
				'{nfba_pkg::ST_OK, 48'd0, 8'd0}},
			'{nfba_pkg::CMD_ALLOC, 32'h0AAA_AAAA, 48'd0,    1'b0,
				'{nfba_pkg::ST_OK, 48'd0, 8'd0}},
			'{nfba_pkg::CMD_ALLOC, 32'h0005_5555, 48'd0,    1'b0,
				'{nfba_pkg::ST_OK, 48'd0, 8'd0}},
			'{nfba_pkg::CMD_ALLOC, 32'd5000,      48'd0,    1'b0,
				'{nfba_pkg::ST_OK, 48'd0, 8'd0}},
			'{nfba_pkg::CMD_FREE,  32'd0,         48'h2000, 1'b0,
				'{nfba_pkg::ST_OK, 48'd0, 8'd0}},
			'{nfba_pkg::CMD_ALLOC, 32'd0,         48'd0,    1'b0,
				'{nfba_pkg::ST_OK, 48'd0, 8'd0}},
			'{nfba_pkg::CMD_FREE,  32'd0, 48'h5555_5555_5555, 1'b1,
				'{nfba_pkg::ST_UNKNOWN, 48'd0, 8'd0}},
			'{nfba_pkg::CMD_FREE,  32'd0, 48'hAAAA_AAAA_AAAA, 1'b1,
				'{nfba_pkg::ST_UNKNOWN, 48'd0, 8'd0}},
			'{nfba_pkg::CMD_ALLOC, 32'd4194303,   48'd0,    1'b0,
				'{nfba_pkg::ST_OK, 48'd0, 8'd0}}
		};
		phases = '{
			'{48'd0,      5'd0,  300, 95, 2},
			'{ADDR_MAX,   5'd12, 60,  45, 16},
			'{48'({$urandom(), $urandom()}), 5'd24, 50, 45, 64},
			'{48'({$urandom(), $urandom()}), 5'd31, 50, 50, 2},
			'{48'h8000_0000_0000, 5'd5, 40, 50, 300}
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed[i])
			send_request(directed[i]);
		drain();

		foreach (phases[p]) begin
			write_reg(nfba_pkg::CFG_BASE, phases[p].base);
			write_reg(nfba_pkg::CFG_SHIFT, 48'(phases[p].shift));
			for (int n = 0; n < phases[p].count; n++)
				send_request(random_request(phases[p]));
			drain();
		end

		$display("testbench: %0d requests; ok %0d, no record %0d, no space %0d, unknown %0d",
			sent, seen[nfba_pkg::ST_OK], seen[nfba_pkg::ST_NO_REC],
			seen[nfba_pkg::ST_NO_SPACE], seen[nfba_pkg::ST_UNKNOWN]);
		$display("testbench: six register settings, shifts 0 to 31, base at both ends");
		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
